// File: rtl/bges_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the button gesture event synthesizer.
package bges_pkg;

	localparam int NUM_BUTTONS = 3;
	localparam int BTN_W       = 2;
	localparam int OP_W        = 2;
	localparam int KIND_W      = 3;
	localparam int TIME_W      = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	localparam int IN_TDATA_W  = ((BTN_W + TIME_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((BTN_W + 7) / 8) * 8;

	// command queue, depth must be a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [CFG_W-1:0] LONG_RST   = CFG_W'(1000);
	localparam logic [CFG_W-1:0] DOUBLE_RST = CFG_W'(300);
	localparam logic [CFG_W-1:0] REPEAT_RST = CFG_W'(100);

	localparam logic [CFG_IDX_W-1:0] CFG_LONG   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = CFG_IDX_W'(2);

	typedef enum logic [OP_W-1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_POLL    = 2'd2
	} opcode_t;

	typedef enum logic [KIND_W-1:0] {
		EV_PRESS  = 3'd0,
		EV_CLICK  = 3'd1,
		EV_DOUBLE = 3'd2,
		EV_LONG   = 3'd3,
		EV_HOLD   = 3'd4
	} ev_kind_t;

	typedef struct packed {
		opcode_t           op;
		logic [BTN_W-1:0]  btn;
		logic [TIME_W-1:0] tnow;
	} cmd_t;

endpackage

// File: rtl/bges_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, drops unused opcodes and out-of-range buttons, registers commands.
module bges_front
	import bges_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,   // button_index, time_now, zero pad
	input  logic [OP_W-1:0]       s_tuser,   // opcode
	output logic                  cmd_valid,
	input  logic                  cmd_ready,
	output cmd_t                  cmd
);

	logic             v_s1;
	cmd_t             cmd_s1;
	logic             keep;
	logic [BTN_W-1:0] btn;

	always_comb begin
		btn  = s_tdata[BTN_W-1:0];
		keep = (s_tuser == OP_POLL) ||
		       (((s_tuser == OP_PRESS) || (s_tuser == OP_RELEASE)) &&
		        ({1'b0, btn} < (BTN_W+1)'(NUM_BUTTONS)));
	end

	assign s_tready  = !v_s1 || cmd_ready;
	assign cmd_valid = v_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1.op   <= opcode_t'(s_tuser);
			cmd_s1.btn  <= btn;
			cmd_s1.tnow <= s_tdata[BTN_W +: TIME_W];
		end
	end

endmodule

// File: rtl/bges_queue.sv
`timescale 1ns / 1ps
// Short command queue between front end and back end.
module bges_queue
	import bges_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	logic              pop;

	assign in_ready  = cnt_q != (QPTR_W+1)'(QDEPTH);
	assign out_valid = cnt_q != '0;
	assign out_cmd   = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_cmd;
		end
	end

endmodule

// File: rtl/bges_back.sv
`timescale 1ns / 1ps
// Back end: per-button state, timing registers, poll sequencer and output register.
module bges_back
	import bges_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  cmd_t                   cmd,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // event_button, zero pad
	output logic [KIND_W-1:0]      m_tuser,  // event_kind
	output logic                   m_tlast
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] long_q;
	logic [CFG_W-1:0] dbl_q;
	logic [CFG_W-1:0] rep_q;

	logic [NUM_BUTTONS-1:0] down_q;
	logic [NUM_BUTTONS-1:0] ldone_q;
	logic [TIME_W-1:0]      since_q [NUM_BUTTONS];
	logic [TIME_W-1:0]      rept_q  [NUM_BUTTONS];
	logic [TIME_W-1:0]      click_q [NUM_BUTTONS];

	logic [BTN_W-1:0]  idx_q;
	logic [TIME_W-1:0] ptime_q;

	logic             pend_v_q;
	logic [BTN_W-1:0] pend_btn_q;
	ev_kind_t         pend_kind_q;

	logic             ov_q;
	logic [BTN_W-1:0] obtn_q;
	ev_kind_t         okind_q;
	logic             olast_q;

	logic [BTN_W-1:0]  sel;
	logic [TIME_W-1:0] tcur;
	logic [TIME_W-1:0] held;
	logic [TIME_W-1:0] rep_el;
	logic [TIME_W-1:0] clk_el;
	logic              long_hit;
	logic              rep_hit;
	logic              dbl_hit;
	logic              out_free;

	logic             push;
	logic [BTN_W-1:0] push_btn;
	ev_kind_t         push_kind;
	logic             push_last;

	logic upd_press;
	logic upd_rel;
	logic upd_click;
	logic upd_dbl;
	logic start;
	logic scan_ev;
	logic scan_go;
	ev_kind_t scan_kind;
	logic flush_go;

	always_comb begin
		sel      = (state_q == S_SCAN) ? idx_q : cmd.btn;
		tcur     = (state_q == S_SCAN) ? ptime_q : cmd.tnow;
		held     = tcur - since_q[sel];
		rep_el   = tcur - rept_q[sel];
		clk_el   = tcur - click_q[sel];
		long_hit = held >= TIME_W'(long_q);
		rep_hit  = rep_el >= TIME_W'(rep_q);
		dbl_hit  = (click_q[sel] != '0) && (clk_el <= TIME_W'(dbl_q));
		out_free = !ov_q || m_tready;

		scan_ev   = down_q[sel] && (ldone_q[sel] ? rep_hit : long_hit);
		scan_kind = ldone_q[sel] ? EV_HOLD : EV_LONG;
		scan_go   = !scan_ev || !pend_v_q || out_free;
		flush_go  = !pend_v_q || out_free;

		cmd_ready = 1'b0;
		push      = 1'b0;
		push_btn  = sel;
		push_kind = EV_PRESS;
		push_last = 1'b1;
		upd_press = 1'b0;
		upd_rel   = 1'b0;
		upd_click = 1'b0;
		upd_dbl   = 1'b0;
		start     = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_PRESS: begin
							if (down_q[sel]) begin
								cmd_ready = 1'b1;
							end else if (out_free) begin
								cmd_ready = 1'b1;
								push      = 1'b1;
								push_kind = EV_PRESS;
								upd_press = 1'b1;
							end
						end
						OP_RELEASE: begin
							if (!down_q[sel]) begin
								cmd_ready = 1'b1;
							end else if (long_hit) begin
								cmd_ready = 1'b1;
								upd_rel   = 1'b1;
							end else if (out_free) begin
								cmd_ready = 1'b1;
								push      = 1'b1;
								push_kind = dbl_hit ? EV_DOUBLE : EV_CLICK;
								upd_rel   = 1'b1;
								upd_dbl   = dbl_hit;
								upd_click = !dbl_hit;
							end
						end
						OP_POLL: begin
							cmd_ready = 1'b1;
							start     = 1'b1;
						end
						default: begin
							cmd_ready = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				push      = scan_go && scan_ev && pend_v_q;
				push_btn  = pend_btn_q;
				push_kind = pend_kind_q;
				push_last = 1'b0;
			end
			S_FLUSH: begin
				push      = pend_v_q && out_free;
				push_btn  = pend_btn_q;
				push_kind = pend_kind_q;
				push_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q <= LONG_RST;
			dbl_q  <= DOUBLE_RST;
			rep_q  <= REPEAT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LONG:   long_q <= cfg_data;
				CFG_DOUBLE: dbl_q  <= cfg_data;
				CFG_REPEAT: rep_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer and button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
			down_q   <= '0;
			ldone_q  <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				since_q[i] <= '0;
				rept_q[i]  <= '0;
				click_q[i] <= '0;
			end
		end else begin
			if (upd_press) begin
				down_q[sel]  <= 1'b1;
				ldone_q[sel] <= 1'b0;
				since_q[sel] <= tcur;
				rept_q[sel]  <= tcur;
			end
			if (upd_rel) begin
				down_q[sel] <= 1'b0;
			end
			if (upd_click) begin
				click_q[sel] <= tcur;
			end
			if (upd_dbl) begin
				click_q[sel] <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_go) begin
						if (scan_ev) begin
							ldone_q[sel] <= 1'b1;
							rept_q[sel]  <= tcur;
							pend_v_q     <= 1'b1;
						end
						if ({1'b0, idx_q} == (BTN_W+1)'(NUM_BUTTONS - 1)) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_FLUSH: begin
					if (flush_go) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ptime_q <= cmd.tnow;
		end
		if (state_q == S_SCAN && scan_go && scan_ev) begin
			pend_btn_q  <= sel;
			pend_kind_q <= scan_kind;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (push) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			obtn_q  <= push_btn;
			okind_q <= push_kind;
			olast_q <= push_last;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {{(OUT_TDATA_W - BTN_W){1'b0}}, obtn_q};
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q) else $error("pending event left in idle");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ({1'b0, idx_q} < (BTN_W+1)'(NUM_BUTTONS)))
		else $error("scan index out of range");

	a_mid_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && push) |=> (m_tvalid && !m_tlast))
		else $error("event moved out mid-poll marked last");

endmodule

// File: rtl/button_gesture_event_synth_top.sv
`timescale 1ns / 1ps
// Top level of the button gesture event synthesizer.
//
// Requests (press, release, poll with a 32-bit ms timestamp) pass a registered front end that
// drops unused opcodes and out-of-range buttons, then a two-entry command queue, then the back
// end that holds per-button state and emits PRESS, CLICK, DOUBLE, LONG and HOLD events, the last
// event of each request flagged on m_tlast. A poll passes a start step, one scan step per
// button and a flush step, driven by the back-end sequencer that checks one button per cycle
// (unless the output stalls) against a shared set of three 32-bit subtract-and-compare units.
// A press or release event passes the front-end register, the queue and the back-end output
// register before it shows on m_tvalid; each poll event waits in a one-entry holding register
// until the next one is found or the scan ends. A full output register stalls the back end,
// which fills the queue and then drops s_tready.
// Config writes take effect at once.
module button_gesture_event_synth_top
	import bges_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // button_index, time_now, zero pad
	input  logic [OP_W-1:0]        s_tuser,   // opcode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // event_button, zero pad
	output logic [KIND_W-1:0]      m_tuser,   // event_kind
	output logic                   m_tlast,   // last_of_run
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	bges_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	bges_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	bges_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
